// ===== rtl/core/scc_pkg.sv =====
`timescale 1ns / 1ps

package scc_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_SLOW_CYCLES   = 2'd0;
  localparam logic [1:0] REG_XTAL_MHZ      = 2'd1;
  localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] SLOW_CYCLES_RESET   = 16'd1024;
  localparam logic [7:0]  XTAL_MHZ_RESET      = 8'd40;
  localparam logic [31:0] TIMEOUT_TICKS_RESET = 32'd4000000;

  // Width of the period divisor, xtal_mhz times slow_cycles.
  localparam int DEN_W = 24;

  // Input word: one reference tick or a start command.
  typedef struct packed {
    logic cmd;
    logic slow_edge;
  } in_word_t;

  // Result word of one calibration.
  typedef struct packed {
    logic [31:0] xtal_count;
    logic [31:0] ratio;
    logic [31:0] period_us;
    logic        timed_out;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_cal;
    logic tick_wait;
    logic tick_count;
    logic finish;
    logic finish_to;
    logic div_period;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic complete;
    logic timeout;
    logic div_done;
  } dp_status_t;

endpackage

// ===== rtl/core/scc_ctrl.sv =====
`timescale 1ns / 1ps

module scc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  scc_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output scc_pkg::dp_cmd_t    cmd,
  input  scc_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT,
    S_COUNT,
    S_DIV_RATIO,
    S_DIV_PERIOD
  } state_t;

  state_t state;
  state_t state_next;
  logic   in_fire;
  logic   armed;

  // Words are taken while idle, waiting or counting. Once a new run is armed, a result
  // that has not been taken yet holds the input side off.
  assign armed    = (state == S_WAIT) || (state == S_COUNT);
  assign in_ready = (state == S_IDLE) || (armed && !out_valid);
  assign in_fire  = in_valid && in_ready;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_fire && in_data.cmd) begin
          cmd.start_cal = 1'b1;
          state_next    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (in_fire) begin
          if (in_data.cmd) begin
            cmd.start_cal = 1'b1;
          end else begin
            cmd.tick_wait = 1'b1;
            if (status.timeout) begin
              cmd.finish    = 1'b1;
              cmd.finish_to = 1'b1;
              state_next    = S_DIV_RATIO;
            end else if (in_data.slow_edge) begin
              state_next = S_COUNT;
            end
          end
        end
      end
      S_COUNT: begin
        if (in_fire) begin
          if (in_data.cmd) begin
            cmd.start_cal = 1'b1;
            state_next    = S_WAIT;
          end else begin
            cmd.tick_count = 1'b1;
            if (status.complete) begin
              cmd.finish = 1'b1;
              state_next = S_DIV_RATIO;
            end else if (status.timeout) begin
              cmd.finish    = 1'b1;
              cmd.finish_to = 1'b1;
              state_next    = S_DIV_RATIO;
            end
          end
        end
      end
      S_DIV_RATIO: begin
        if (status.div_done) begin
          cmd.div_period = 1'b1;
          state_next     = S_DIV_PERIOD;
        end
      end
      S_DIV_PERIOD: begin
        if (status.div_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DIV_PERIOD && status.div_done) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/scc_dp.sv =====
`timescale 1ns / 1ps

module scc_dp #(
  parameter int FRACTION_BITS = 19
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  scc_pkg::in_word_t   in_data,
  input  scc_pkg::dp_cmd_t    cmd,
  output scc_pkg::dp_status_t status,
  output scc_pkg::out_word_t  out_data
);

  localparam int DW = scc_pkg::DEN_W;
  // Dividend width: count shifted by the fraction bits, plus one rounding bit.
  localparam int NW = 32 + FRACTION_BITS + 1;
  localparam int IW = $clog2(NW);

  // Configuration registers.
  logic [15:0] slow_cycles;
  logic [7:0]  xtal_mhz;
  logic [31:0] timeout_ticks;

  // Counters.
  logic [31:0] elapsed;
  logic [31:0] tick_cnt;
  logic [15:0] edge_cnt;

  // Result and divider registers.
  logic [31:0]   count_r;
  logic          timed_out_r;
  logic [31:0]   ratio_r;
  logic [31:0]   period_r;
  logic [DW-1:0] prod;
  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [DW-1:0] rem;
  logic [31:0]   quo;
  logic [IW-1:0] iter;
  logic          div_busy;
  logic          div_pass;
  logic          div_done;

  logic [15:0]   eff_cycles;
  logic [7:0]    eff_mhz;
  logic [31:0]   elapsed_inc;
  logic [31:0]   tick_inc;
  logic [15:0]   edge_inc;
  logic [31:0]   count_sel;
  logic [NW-1:0] num_ratio;
  logic [NW-1:0] num_period;
  logic [DW:0]   rem_shift;
  logic [DW:0]   rem_diff;
  logic          qbit;
  logic [31:0]   quo_next;
  logic          div_last;

  // Clamp the configuration to its usable range.
  assign eff_cycles = (slow_cycles == 16'd0) ? 16'd1 : slow_cycles;
  assign eff_mhz    = (xtal_mhz < 8'd2) ? 8'd2 : xtal_mhz;

  // Saturating counter increments for the current tick.
  assign elapsed_inc = (elapsed == 32'hFFFF_FFFF) ? elapsed : elapsed + 32'd1;
  assign tick_inc    = (tick_cnt == 32'hFFFF_FFFF) ? tick_cnt : tick_cnt + 32'd1;
  assign edge_inc    = (in_data.slow_edge && edge_cnt != 16'hFFFF) ?
                       edge_cnt + 16'd1 : edge_cnt;

  assign status.complete = (edge_inc >= eff_cycles);
  assign status.timeout  = (elapsed_inc >= timeout_ticks);
  assign status.div_done = div_done;

  // Dividends for the two passes of the shared divider.
  assign count_sel  = cmd.finish_to ? 32'd0 : tick_inc;
  assign num_ratio  = {1'b0, count_sel, {FRACTION_BITS{1'b0}}};
  assign num_period = {1'b0, count_r, {FRACTION_BITS{1'b0}}}
                    + NW'(prod >> 1) - NW'(1);

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  assign rem_shift = {rem, num[NW-1]};
  assign rem_diff  = rem_shift - {1'b0, den};
  assign qbit      = (rem_shift >= {1'b0, den});
  assign quo_next  = {quo[30:0], qbit};
  assign div_last  = (iter == IW'(NW - 1));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_cycles   <= scc_pkg::SLOW_CYCLES_RESET;
      xtal_mhz      <= scc_pkg::XTAL_MHZ_RESET;
      timeout_ticks <= scc_pkg::TIMEOUT_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        scc_pkg::REG_SLOW_CYCLES:   slow_cycles   <= cfg_data[15:0];
        scc_pkg::REG_XTAL_MHZ:      xtal_mhz      <= cfg_data[7:0];
        scc_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Period divisor, registered after the multiply.
  always_ff @(posedge clk) begin
    prod <= DW'(eff_mhz) * DW'(eff_cycles);
  end

  // Tick and edge counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed  <= '0;
      tick_cnt <= '0;
      edge_cnt <= '0;
    end else if (cmd.start_cal) begin
      elapsed  <= '0;
      tick_cnt <= '0;
      edge_cnt <= '0;
    end else if (cmd.tick_wait) begin
      elapsed <= elapsed_inc;
    end else if (cmd.tick_count) begin
      elapsed  <= elapsed_inc;
      tick_cnt <= tick_inc;
      edge_cnt <= edge_inc;
    end
  end

  // Divider control.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
      div_pass <= 1'b0;
      iter     <= '0;
    end else begin
      div_done <= 1'b0;
      if (cmd.finish || cmd.div_period) begin
        div_busy <= 1'b1;
        div_pass <= cmd.div_period;
        iter     <= '0;
      end else if (div_busy) begin
        iter <= iter + IW'(1);
        if (div_last) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  // Divider datapath and result registers.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      count_r     <= count_sel;
      timed_out_r <= cmd.finish_to;
      num         <= num_ratio;
      den         <= DW'(eff_cycles);
      rem         <= '0;
      quo         <= '0;
    end else if (cmd.div_period) begin
      num <= num_period;
      den <= prod;
      rem <= '0;
      quo <= '0;
    end else if (div_busy) begin
      num <= {num[NW-2:0], 1'b0};
      rem <= qbit ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
      quo <= quo_next;
      if (div_last) begin
        if (div_pass) begin
          period_r <= quo_next;
        end else begin
          ratio_r <= quo_next;
        end
      end
    end
  end

  assign out_data.xtal_count = count_r;
  assign out_data.ratio      = ratio_r;
  assign out_data.period_us  = period_r;
  assign out_data.timed_out  = timed_out_r;

endmodule

// ===== rtl/core/slow_clock_calibrator.sv =====
`timescale 1ns / 1ps

// One-off slow clock calibrator.
// Input words arrive on in_valid/in_ready/in_data: cmd = 1 starts a run and
// clears the counters, cmd = 0 is one reference clock tick whose slow_edge bit
// flags a slow clock rising edge. Counting starts at the first slow edge and
// stops once slow_cycles slow periods have passed, or gives up when
// timeout_ticks ticks have elapsed since the start.
// While counting, one tick word is taken every cycle unless a finished word is
// still pending. At the end of a run the block stops taking words and a single
// bit-serial restoring divider works out the ratio and then the period, one
// quotient bit per cycle for each; the result word then appears on
// out_valid/out_ready/out_data.
// A finished word is held in the output register until it is taken. Ticks and
// a new start are still taken meanwhile, but once a new run is armed the input
// side stalls until the pending word leaves.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 slow
// cycles, 1 crystal MHz, 2 timeout ticks) at once; other indexes are ignored.
// Synchronous reset returns the registers to their defaults and the block to
// idle with no word pending.
module slow_clock_calibrator #(
  parameter int FRACTION_BITS = 19
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  scc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output scc_pkg::out_word_t out_data
);

  scc_pkg::dp_cmd_t    cmd;
  scc_pkg::dp_status_t status;

  // Sequencer for counting and the two division passes.
  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Counters, configuration and the shared divider.
  scc_dp #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/calibration_checker.sv =====
`timescale 1ns / 1ps

// Watches the configuration port and both word channels of the calibrator.
// It keeps its own copy of the calibration state and registers, works out the
// result word that each accepted input word causes, and compares every
// accepted result word against the oldest one still due.
module calibration_checker #(
  parameter int FRACTION_BITS = 19
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  scc_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  scc_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 pending
);

  typedef enum logic [1:0] {
    CAL_IDLE     = 2'd0,
    CAL_ARMED    = 2'd1,
    CAL_COUNTING = 2'd2
  } cal_phase_t;

  // Register copies.
  logic [15:0] slow_cycles_q;
  logic [7:0]  xtal_mhz_q;
  logic [31:0] timeout_q;

  // Calibration state.
  cal_phase_t  cal_phase;
  logic [31:0] tick_cnt;
  logic [15:0] slow_cnt;
  logic [31:0] elapsed_cnt;

  scc_pkg::out_word_t results_due[$];
  int                 errors = 0;

  assign fail_count = errors;

  task automatic report_error(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Result word for a finished run: count, ratio and rounded period.
  function automatic scc_pkg::out_word_t calibration_word(input logic [31:0] count,
                                                          input logic gave_up);
    scc_pkg::out_word_t w;
    logic [63:0] cycles;
    logic [63:0] mhz;
    logic [63:0] num;
    logic [63:0] den;
    cycles = (slow_cycles_q == 16'd0) ? 64'd1 : {48'd0, slow_cycles_q};
    mhz = (xtal_mhz_q < 8'd2) ? 64'd2 : {56'd0, xtal_mhz_q};
    num = {32'd0, count} << FRACTION_BITS;
    den = mhz * cycles;
    w.xtal_count = count;
    w.ratio = 32'(num / cycles);
    w.period_us = 32'((num + den / 64'd2 - 64'd1) / den);
    w.timed_out = gave_up;
    return w;
  endfunction

  // Advance the calibration by one accepted input word.
  task automatic count_tick(input scc_pkg::in_word_t w);
    logic [31:0] eff_cycles;
    logic        finished;
    eff_cycles = (slow_cycles_q == 16'd0) ? 32'd1 : {16'd0, slow_cycles_q};
    finished = 1'b0;
    if (w.cmd) begin
      cal_phase = CAL_ARMED;
      tick_cnt = '0;
      slow_cnt = '0;
      elapsed_cnt = '0;
    end else if (cal_phase != CAL_IDLE) begin
      if (elapsed_cnt != '1) elapsed_cnt++;
      if (cal_phase == CAL_ARMED) begin
        // The first slow edge only opens the counting window.
        if (w.slow_edge) begin
          cal_phase = CAL_COUNTING;
          tick_cnt = '0;
          slow_cnt = '0;
        end
      end else begin
        if (tick_cnt != '1) tick_cnt++;
        if (w.slow_edge && slow_cnt != '1) slow_cnt++;
        if ({16'd0, slow_cnt} >= eff_cycles) begin
          cal_phase = CAL_IDLE;
          results_due.push_back(calibration_word(tick_cnt, 1'b0));
          finished = 1'b1;
        end
      end
      // Completion on the same tick takes priority over the timeout.
      if (!finished && elapsed_cnt >= timeout_q) begin
        cal_phase = CAL_IDLE;
        results_due.push_back(calibration_word(32'd0, 1'b1));
      end
    end
  endtask

  task automatic check_word(input scc_pkg::out_word_t got);
    scc_pkg::out_word_t want;
    if (results_due.size() == 0) begin
      report_error("result word arrived with nothing due");
    end else begin
      want = results_due.pop_front();
      if (got.xtal_count !== want.xtal_count)
        report_error($sformatf("xtal_count %h, expected %h", got.xtal_count, want.xtal_count));
      if (got.ratio !== want.ratio)
        report_error($sformatf("ratio %h, expected %h", got.ratio, want.ratio));
      if (got.period_us !== want.period_us)
        report_error($sformatf("period_us %h, expected %h", got.period_us, want.period_us));
      if (got.timed_out !== want.timed_out)
        report_error($sformatf("timed_out %b, expected %b", got.timed_out, want.timed_out));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      slow_cycles_q = scc_pkg::SLOW_CYCLES_RESET;
      xtal_mhz_q = scc_pkg::XTAL_MHZ_RESET;
      timeout_q = scc_pkg::TIMEOUT_TICKS_RESET;
      cal_phase = CAL_IDLE;
      tick_cnt = '0;
      slow_cnt = '0;
      elapsed_cnt = '0;
      results_due.delete();
    end else begin
      // Register writes take effect at once; other indexes are ignored.
      if (cfg_we) begin
        case (cfg_index)
          scc_pkg::REG_SLOW_CYCLES:   slow_cycles_q = cfg_data[15:0];
          scc_pkg::REG_XTAL_MHZ:      xtal_mhz_q = cfg_data[7:0];
          scc_pkg::REG_TIMEOUT_TICKS: timeout_q = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_word(out_data);
      if (in_valid && in_ready) count_tick(in_data);
    end
    pending <= results_due.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int FRACTION_BITS = 19;
  // Idle wait after a run, long enough for both divider passes.
  localparam int DRAIN_CYCLES = 160;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_WORDS = 560;
  localparam int LONG_RUN_TICKS = 150;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  scc_pkg::in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  scc_pkg::out_word_t out_data;

  int   fails;
  int   pending;
  int   quiet_cycles = 0;
  int   burst_left = 0;
  int   words_sent = 0;
  int   gen_cycles = 1;
  logic random_part = 1'b0;

  slow_clock_calibrator #(.FRACTION_BITS(FRACTION_BITS)) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  calibration_checker #(.FRACTION_BITS(FRACTION_BITS)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one word and hold it until accepted; words go out in bursts.
  task automatic send_word(input logic cmd, input logic slow_bit);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: cmd, slow_edge: slow_bit};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  // Wait until every due word has arrived and the divider has gone quiet.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all registers, with junk above the slow cycles and MHz fields, plus an unused index.
  task automatic program_regs(input logic [15:0] sc, input logic [7:0] mhz,
                              input logic [31:0] limit);
    cfg_we <= 1'b1;
    cfg_index <= scc_pkg::REG_SLOW_CYCLES;
    cfg_data <= {16'($urandom), sc};
    @(posedge clk);
    cfg_index <= scc_pkg::REG_XTAL_MHZ;
    cfg_data <= {24'($urandom), mhz};
    @(posedge clk);
    cfg_index <= scc_pkg::REG_TIMEOUT_TICKS;
    cfg_data <= limit;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_cycles = (sc == 16'd0) ? 1 : int'(sc);
  endtask

  // One calibration run: start, a few idle ticks, the opening edge, then
  // slow periods of random length. Some runs are cut short or are noise.
  task automatic run_calibration(input int gap_max);
    int roll;
    int pre;
    int gap;
    int broken_at;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 4)) send_word(1'b0, 1'($urandom_range(0, 1)));
    end else begin
      broken_at = (roll < 18) ? $urandom_range(0, gen_cycles) : -1;
      send_word(1'b1, 1'($urandom_range(0, 1)));
      pre = $urandom_range(0, 3);
      repeat (pre) send_word(1'b0, 1'b0);
      send_word(1'b0, 1'b1);
      for (int k = 0; k < gen_cycles; k++) begin
        if (k == broken_at) break;
        gap = $urandom_range(0, gap_max);
        repeat (gap) send_word(1'b0, 1'b0);
        send_word(1'b0, 1'b1);
      end
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int rand_base;
    int phase_base;
    int phase_no;
    int gap_max;
    logic [15:0] sc;
    logic [7:0]  mhz;
    logic [31:0] limit;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Ticks while idle are ignored.
    send_word(1'b0, 1'b1);
    send_word(1'b0, 1'b0);
    settle();

    // Completion and timeout on the same tick, then a restart that times out
    // while still waiting for the first edge. A crystal of 1 MHz counts as 2.
    program_regs(16'd1, 8'd1, 32'd3);
    send_word(1'b1, 1'b1);
    send_word(1'b0, 1'b1);
    send_word(1'b0, 1'b0);
    send_word(1'b0, 1'b1);
    send_word(1'b1, 1'b0);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b0);
    send_word(1'b0, 1'b0);
    send_word(1'b0, 1'b0);
    settle();

    // A zero timeout gives up on the first tick.
    program_regs(16'd1, 8'd1, 32'd0);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b1);
    settle();

    // Zero slow cycles and zero MHz, then a restart during counting.
    program_regs(16'd0, 8'd0, '1);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b1);
    send_word(1'b0, 1'b1);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b1);
    send_word(1'b1, 1'b1);
    send_word(1'b0, 1'b1);
    send_word(1'b0, 1'b1);
    settle();

    // Largest settings; the timeout ends the run.
    program_regs(16'hFFFF, 8'hFF, 32'd4);
    send_word(1'b1, 1'b0);
    repeat (4) send_word(1'b0, 1'b1);
    settle();

    // A long single period at the fastest crystal.
    program_regs(16'd1, 8'hFF, '1);
    send_word(1'b1, 1'b0);
    send_word(1'b0, 1'b1);
    repeat (LONG_RUN_TICKS) send_word(1'b0, 1'b0);
    send_word(1'b0, 1'b1);
    settle();

    // Random runs over several register settings.
    random_part <= 1'b1;
    rand_base = words_sent;
    phase_no = 0;
    while (words_sent - rand_base < RANDOM_WORDS) begin
      settle();
      gap_max = $urandom_range(0, 5);
      case (phase_no)
        0: begin sc = 16'd1; mhz = 8'd2; limit = '1; end
        1: begin sc = 16'd4; mhz = 8'hFF; limit = scc_pkg::TIMEOUT_TICKS_RESET; end
        2: begin sc = 16'd3; mhz = 8'd1; limit = 32'd20; end
        default: begin
          sc = 16'($urandom_range(1, 8));
          mhz = 8'($urandom_range(0, 255));
          limit = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(6, 40)) : $urandom;
        end
      endcase
      program_regs(sc, mhz, limit);
      phase_base = words_sent;
      while (words_sent - phase_base < RANDOM_WORDS / 8 &&
             words_sent - rand_base < RANDOM_WORDS)
        run_calibration(gap_max);
      phase_no++;
    end

    settle();
    if (fails == 0 && pending == 0) begin
      $display("PASS slow_clock_calibrator");
    end else begin
      $display("FAIL slow_clock_calibrator");
    end
    $finish;
  end

  // Result side: stall patterns of random length, and a couple of long
  // hold-offs while a word waits so that the input side backs up.
  initial begin
    int stretch;
    int mode;
    int holds;
    holds = 0;
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      stretch = $urandom_range(20, 200);
      repeat (stretch) begin
        @(posedge clk);
        if (random_part && holds < 2 && out_valid) begin
          out_ready <= 1'b0;
          holds++;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("FAIL slow_clock_calibrator");
      $finish;
    end
  end

endmodule
